// ===== rtl/shell_command_tokenizer_assert.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef SHELL_COMMAND_TOKENIZER_ASSERT_SVH
`define SHELL_COMMAND_TOKENIZER_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define SCT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sct_pkg.sv =====
// Package: types, codes and character classes of the command tokenizer.
`timescale 1ns / 1ps
package sct_pkg;

   localparam int CH_W      = 8;
   localparam int KIND_W    = 3;
   localparam int NUM_SLOTS = 3;
   localparam int SLOT_W    = 2;
   localparam int CMD_FIFO_DEPTH = 2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_SYM    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_END    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ACCEPT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REJECT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DROP   = 3'd4;

   // characters
   localparam logic [CH_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CH_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CH_W-1:0] CH_SPACE   = 8'd32;
   localparam logic [CH_W-1:0] CH_DOLLAR  = 8'd36;
   localparam logic [CH_W-1:0] CH_UNDER   = 8'd95;
   localparam logic [CH_W-1:0] CH_SLASH   = 8'd47;
   localparam logic [CH_W-1:0] CH_DOT     = 8'd46;
   localparam logic [CH_W-1:0] CH_PIPE    = 8'd124;
   localparam logic [CH_W-1:0] CH_AMP     = 8'd38;
   localparam logic [CH_W-1:0] CH_SEMI    = 8'd59;
   localparam logic [CH_W-1:0] CH_GT      = 8'd62;
   localparam logic [CH_W-1:0] CH_LT      = 8'd60;
   localparam logic [CH_W-1:0] CH_LPAREN  = 8'd40;
   localparam logic [CH_W-1:0] CH_RPAREN  = 8'd41;
   localparam logic [CH_W-1:0] CH_0       = 8'd48;
   localparam logic [CH_W-1:0] CH_9       = 8'd57;
   localparam logic [CH_W-1:0] CH_LA      = 8'd97;
   localparam logic [CH_W-1:0] CH_LZ      = 8'd122;
   localparam logic [CH_W-1:0] CH_UA      = 8'd65;
   localparam logic [CH_W-1:0] CH_UZ      = 8'd90;

   // up to three results produced by one request, packed from slot 0
   typedef struct packed {
      logic [SLOT_W-1:0]                     count;
      logic [NUM_SLOTS-1:0][KIND_W-1:0]      kind;
      logic [NUM_SLOTS-1:0][CH_W-1:0]        sym;
   } cmd_type;

   function automatic logic is_word(input logic [CH_W-1:0] c);
      return c == CH_DOLLAR || c == CH_UNDER || c == CH_SLASH || c == CH_DOT ||
             (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LZ) ||
             (c >= CH_UA && c <= CH_UZ);
   endfunction

   function automatic logic is_pair(input logic [CH_W-1:0] c);
      return c == CH_GT || c == CH_AMP || c == CH_PIPE;
   endfunction

   function automatic logic is_oper(input logic [CH_W-1:0] c);
      return c == CH_SEMI || c == CH_LT || c == CH_LPAREN || c == CH_RPAREN;
   endfunction

   function automatic logic is_blank(input logic [CH_W-1:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

endpackage

// ===== rtl/sct_front.sv =====
// Front end: line/token state and per-request result command builder.
`timescale 1ns / 1ps
module sct_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  logic [sct_pkg::CH_W-1:0]  req_ch,
   input  logic                      req_end_of_input,
   input  logic                      cmd_full,
   output logic                      cmd_push,
   output sct_pkg::cmd_type          cmd_data
);

   logic [sct_pkg::CH_W-1:0] prev_char_ff, prev_char_in;
   logic prev_valid_ff, prev_valid_in;
   logic pair_open_ff, pair_open_in;
   logic token_open_ff, token_open_in;
   logic line_bad_ff, line_bad_in;
   logic accept;

   assign accept = req_push && !cmd_full;

   always_comb begin
      sct_pkg::cmd_type         cmd;
      logic [sct_pkg::SLOT_W-1:0] n;
      logic [sct_pkg::CH_W-1:0]   c;
      cmd           = '0;
      n             = '0;
      c             = req_ch;
      prev_char_in  = prev_char_ff;
      prev_valid_in = prev_valid_ff;
      pair_open_in  = pair_open_ff;
      token_open_in = token_open_ff;
      line_bad_in   = line_bad_ff;

      if (req_end_of_input) begin
         if (prev_valid_ff || token_open_ff) begin
            if (token_open_ff) begin
               cmd.kind[n] = sct_pkg::KIND_END;
               n = n + 2'd1;
            end
            cmd.kind[n] = sct_pkg::KIND_DROP;
            n = n + 2'd1;
         end
         prev_char_in  = '0;
         prev_valid_in = 1'b0;
         pair_open_in  = 1'b0;
         token_open_in = 1'b0;
         line_bad_in   = 1'b0;
      end else if (c == sct_pkg::CH_NEWLINE) begin
         if (token_open_ff) begin
            cmd.kind[n] = sct_pkg::KIND_END;
            n = n + 2'd1;
         end
         cmd.kind[n] = line_bad_ff ? sct_pkg::KIND_REJECT : sct_pkg::KIND_ACCEPT;
         n = n + 2'd1;
         prev_char_in  = '0;
         prev_valid_in = 1'b0;
         pair_open_in  = 1'b0;
         token_open_in = 1'b0;
         line_bad_in   = 1'b0;
      end else begin
         if (!sct_pkg::is_pair(c)) pair_open_in = 1'b0;
         if (sct_pkg::is_blank(c)) begin
            if (token_open_ff) begin
               cmd.kind[n] = sct_pkg::KIND_END;
               n = n + 2'd1;
            end
            token_open_in = 1'b0;
         end else if (sct_pkg::is_word(c)) begin
            // a word right after > & | closes that operator first
            if (token_open_ff && prev_valid_ff && sct_pkg::is_pair(prev_char_ff)) begin
               cmd.kind[n] = sct_pkg::KIND_END;
               n = n + 2'd1;
            end
            cmd.kind[n] = sct_pkg::KIND_SYM;
            cmd.sym[n]  = c;
            n = n + 2'd1;
            token_open_in = 1'b1;
         end else if (sct_pkg::is_pair(c)) begin
            if (pair_open_ff && prev_valid_ff && prev_char_ff == c) begin
               cmd.kind[n] = sct_pkg::KIND_SYM;
               cmd.sym[n]  = c;
               n = n + 2'd1;
               cmd.kind[n] = sct_pkg::KIND_END;
               n = n + 2'd1;
               token_open_in = 1'b0;
               pair_open_in  = 1'b0;
            end else begin
               if (token_open_ff) begin
                  cmd.kind[n] = sct_pkg::KIND_END;
                  n = n + 2'd1;
               end
               cmd.kind[n] = sct_pkg::KIND_SYM;
               cmd.sym[n]  = c;
               n = n + 2'd1;
               token_open_in = 1'b1;
               pair_open_in  = 1'b1;
            end
         end else if (sct_pkg::is_oper(c)) begin
            if (token_open_ff) begin
               cmd.kind[n] = sct_pkg::KIND_END;
               n = n + 2'd1;
            end
            cmd.kind[n] = sct_pkg::KIND_SYM;
            cmd.sym[n]  = c;
            n = n + 2'd1;
            cmd.kind[n] = sct_pkg::KIND_END;
            n = n + 2'd1;
            token_open_in = 1'b0;
         end else begin
            line_bad_in = 1'b1;
         end
         prev_char_in  = c;
         prev_valid_in = 1'b1;
      end
      cmd.count = n;
      cmd_data  = cmd;
      cmd_push  = accept && (n != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_char_ff  <= '0;
         prev_valid_ff <= 1'b0;
         pair_open_ff  <= 1'b0;
         token_open_ff <= 1'b0;
         line_bad_ff   <= 1'b0;
      end else if (accept) begin
         prev_char_ff  <= prev_char_in;
         prev_valid_ff <= prev_valid_in;
         pair_open_ff  <= pair_open_in;
         token_open_ff <= token_open_in;
         line_bad_ff   <= line_bad_in;
      end
   end

endmodule

// ===== rtl/sct_cmd_fifo.sv =====
// Short register queue of result commands between front and back end.
`timescale 1ns / 1ps
`include "shell_command_tokenizer_assert.svh"
module sct_cmd_fifo #(
   parameter int DEPTH = sct_pkg::CMD_FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sct_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output sct_pkg::cmd_type pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   sct_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   `SCT_ASSERT(a_no_push_full, clock, reset, !(push && full), "push into full command queue")
   `SCT_ASSERT(a_no_pop_empty, clock, reset, !(pop && empty), "pop from empty command queue")

endmodule

// ===== rtl/sct_back.sv =====
// Back end: walks one command's result slots onto the result port.
`timescale 1ns / 1ps
`include "shell_command_tokenizer_assert.svh"
module sct_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_empty,
   input  sct_pkg::cmd_type            cmd_data,
   output logic                        cmd_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [sct_pkg::KIND_W-1:0]  rsp_kind,
   output logic [sct_pkg::CH_W-1:0]    rsp_sym,
   output logic                        rsp_last
);

   sct_pkg::cmd_type cur_ff;
   logic busy_ff, busy_in;
   logic [sct_pkg::SLOT_W-1:0] idx_ff, idx_in;
   logic is_last;
   logic load;

   assign is_last   = (idx_ff + 2'd1) == cur_ff.count;
   assign rsp_empty = !busy_ff;
   assign rsp_kind  = cur_ff.kind[idx_ff];
   assign rsp_sym   = cur_ff.sym[idx_ff];
   assign rsp_last  = is_last;
   // take the next command as the last slot of this one leaves
   assign load      = !cmd_empty && (!busy_ff || (rsp_pop && is_last));
   assign cmd_pop   = load;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (busy_ff && rsp_pop) begin
         if (is_last) busy_in = 1'b0;
         else         idx_in  = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) cur_ff <= cmd_data;
   end

   `SCT_ASSERT(a_cmd_nonempty, clock, reset, !busy_ff || cur_ff.count != '0, "empty command loaded")
   `SCT_ASSERT(a_idx_in_range, clock, reset, !busy_ff || idx_ff < cur_ff.count, "slot index past count")
   `SCT_ASSERT_NEXT(a_slot_advance, clock, reset, busy_ff && rsp_pop && !is_last, busy_ff && idx_ff == $past(idx_ff) + 2'd1, "slot did not advance")

endmodule

// ===== rtl/shell_command_tokenizer.sv =====
// Shell command tokenizer: one character per request in, token stream out.
//
// Request channel (req_*): push a character byte (req_ch) or an end-of-input
// mark (req_end_of_input) while req_full is low. Each request yields zero to
// three results: token symbols, token-end markers and a line verdict
// (accepted, rejected, dropped).
// Result channel (rsp_*): while rsp_empty is low the oldest result sits on
// rsp_kind / rsp_sym / rsp_last; rsp_pop takes it. rsp_last flags the final
// result of a request.
// The first result of a request is written into the command queue, then loaded
// into the back end's slot register, and only then sits on the rsp_ ports.
// Results leave at one per cycle while the receiver pops and results are
// queued, set by the back end emitting one slot per cycle.
// The front end accepts a new request every cycle while the command queue
// has room, so a stalled receiver only backs up once the queue fills.
// Reset (synchronous, active high) starts a fresh line and empties the queue.
`timescale 1ns / 1ps
module shell_command_tokenizer #(
   parameter int CMD_FIFO_DEPTH = sct_pkg::CMD_FIFO_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [sct_pkg::CH_W-1:0]    req_ch,
   input  logic                        req_end_of_input,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [sct_pkg::KIND_W-1:0]  rsp_kind,
   output logic [sct_pkg::CH_W-1:0]    rsp_sym,
   output logic                        rsp_last
);

   sct_pkg::cmd_type push_cmd;
   sct_pkg::cmd_type pop_cmd;
   logic cmd_push;
   logic cmd_pop;
   logic cmd_full;
   logic cmd_empty;

   // request is refused only when the command queue is full
   assign req_full = cmd_full;

   sct_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_ch           (req_ch),
      .req_end_of_input (req_end_of_input),
      .cmd_full         (cmd_full),
      .cmd_push         (cmd_push),
      .cmd_data         (push_cmd)
   );

   sct_cmd_fifo #(
      .DEPTH (CMD_FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (pop_cmd),
      .empty     (cmd_empty)
   );

   sct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (pop_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_kind  (rsp_kind),
      .rsp_sym   (rsp_sym),
      .rsp_last  (rsp_last)
   );

endmodule
